@@ rtl/core/kalman_filter_position_velocity_assert.svh @@
// Assertion macros for the position and velocity tracking filter.
`ifndef KALMAN_FILTER_POSITION_VELOCITY_ASSERT_SVH
`define KALMAN_FILTER_POSITION_VELOCITY_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define KF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define KF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/core/kfpv_pkg.sv @@
// Shared constants and types for the position and velocity tracking filter.
package kfpv_pkg;
	localparam int SW = 32;
	localparam int VW = 31;
	localparam int AW = 80;
	localparam int MW = 48;

	// Operand and product widths of the shared multiplier.
	localparam int MUL_AW = 40;
	localparam int MUL_BW = 33;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// Width of the divider's step counter.
	localparam int DIV_CW = $clog2(AW + 1);

	// Saturation bounds of a state word and the limit on large prediction terms.
	localparam logic signed [AW-1:0] SMAX = AW'(64'sh7FFFFFFF);
	localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
	localparam logic signed [AW-1:0] BIG = AW'(1) <<< 38;

	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_ACCEL  = 2'd1;
	localparam logic [1:0] REG_RNOISE = 2'd2;
	localparam logic [1:0] REG_QNOISE = 2'd3;

	// Request to the shared divider: signed numerator, positive denominator.
	typedef struct packed {
		logic               start;
		logic signed [AW-1:0] num;
		logic [MW-1:0]      den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [AW-1:0] quo;
	} div_rsp_t;

	// Rounded right shift, round half up.
	function automatic logic signed [AW-1:0] rsh(input logic signed [AW-1:0] x,
		input int s);
		logic signed [AW-1:0] y;
		y = x + (AW'(1) <<< (s - 1));
		return y >>> s;
	endfunction

	function automatic logic signed [AW-1:0] clampv(input logic signed [AW-1:0] x,
		input logic signed [AW-1:0] lo, input logic signed [AW-1:0] hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction
endpackage

@@ rtl/core/kfpv_div.sv @@
// Restoring bit-serial divider with rounding to nearest, half away from zero.
module kfpv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  kfpv_pkg::div_req_t req,
	output kfpv_pkg::div_rsp_t rsp
);
	import kfpv_pkg::*;

	logic [AW-1:0]     rem_q;
	logic [AW-1:0]     quo_q;
	logic [MW-1:0]     den_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [AW:0]       trial;
	logic [AW-1:0]     mag;
	logic [AW-1:0]     rnd;

	// Magnitude of the numerator plus half the denominator.
	always_comb begin
		mag = req.num[AW-1] ? AW'(-req.num) : AW'(req.num);
		rnd = mag + AW'(req.den >> 1);
		trial = {rem_q, quo_q[AW-1]} - {(AW+1-MW)'(0), den_q};
	end

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == DIV_CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CW'(AW);
				rem_q <= '0;
				quo_q <= rnd;
				den_q <= req.den;
				neg_q <= req.num[AW-1];
			end else if (busy_q) begin
				if (!trial[AW]) begin
					rem_q <= trial[AW-1:0];
					quo_q <= {quo_q[AW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[AW-2:0], quo_q[AW-1]};
					quo_q <= {quo_q[AW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp = '{done: done_q, quo: (neg_q ? -$signed(quo_q) : $signed(quo_q))};
endmodule

@@ rtl/core/kalman_filter_position_velocity.sv @@
// Top level of the position and velocity tracking filter.
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | measured_position
//  out     | output    | out_valid/out_stall | estimates, variance
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
// An item takes seven steps on the shared multiplier, then five divisions in the shared
// bit-serial divider (80 quotient bits each, plus request and done hand-off) and one
// step to publish, which waits while a held result is stalled; the next beat is taken
// after publishing. A denominator that is not positive skips the five divisions.
// Reset clears the state to zero and loads the register defaults.
// A held result does not block the next measurement; only publishing waits for it.
module kalman_filter_position_velocity (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] measured_position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] position_estimate,
	output logic signed [31:0] velocity_estimate,
	output logic [30:0] position_variance,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import kfpv_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_AT, S_VT, S_PRED, S_COV0, S_COV1, S_COV2, S_DEN,
		S_D00, S_D01, S_D11, S_DP, S_DV, S_FIN
	} state_t;

	state_t state_q;
	logic [23:0] t_q;
	logic signed [31:0] a_q;
	logic [30:0] r_q, qn_q;
	logic signed [AW-1:0] p_q, v_q, c00_q, c01_q, c11_q, z_q, at_q, s_q;
	logic signed [AW-1:0] tc01_q, tc11_q, u00_q, u01_q, u11_q;
	logic signed [AW-1:0] innov, s_n, prod, div_num_q;
	logic signed [MUL_AW-1:0] mop_a;
	logic signed [MUL_BW-1:0] mop_b;
	logic signed [MUL_PW-1:0] prod_m;
	logic div_start_q, div_issue, publish;
	div_req_t dreq;
	div_rsp_t drsp;

	kfpv_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign innov = z_q - p_q;
	assign s_n = c00_q + AW'(qn_q);
	assign prod_m = mop_a * mop_b;
	assign prod = AW'(prod_m);
	assign dreq = '{start: div_start_q, num: div_num_q, den: MW'(s_q)};

	// Operand selection for the shared multiplier.
	always_comb begin
		mop_a = '0;
		mop_b = '0;
		case (state_q)
			S_AT:   begin mop_a = MUL_AW'(a_q); mop_b = MUL_BW'(t_q); end
			S_VT:   begin mop_a = v_q[MUL_AW-1:0]; mop_b = MUL_BW'(t_q); end
			S_PRED: begin mop_a = at_q[MUL_AW-1:0]; mop_b = MUL_BW'(t_q); end
			S_COV0: begin mop_a = c01_q[MUL_AW-1:0]; mop_b = MUL_BW'(t_q); end
			S_COV1: begin mop_a = c11_q[MUL_AW-1:0]; mop_b = MUL_BW'(t_q); end
			S_COV2: begin
				mop_a = (tc11_q > BIG) ? BIG[MUL_AW-1:0] : tc11_q[MUL_AW-1:0];
				mop_b = MUL_BW'(t_q);
			end
			S_DEN:  begin mop_a = c00_q[MUL_AW-1:0]; mop_b = MUL_BW'(qn_q); end
			S_D00:  begin mop_a = c01_q[MUL_AW-1:0]; mop_b = MUL_BW'(qn_q); end
			S_D01:  begin mop_a = c01_q[MUL_AW-1:0]; mop_b = c01_q[MUL_BW-1:0]; end
			S_D11:  begin mop_a = c00_q[MUL_AW-1:0]; mop_b = innov[MUL_BW-1:0]; end
			S_DP:   begin mop_a = c01_q[MUL_AW-1:0]; mop_b = innov[MUL_BW-1:0]; end
			default: begin mop_a = '0; mop_b = '0; end
		endcase
	end

	// A division starts after a positive denominator check and after each earlier quotient.
	always_comb begin
		div_issue = 1'b0;
		if (state_q == S_DEN)
			div_issue = (s_n > 0);
		else if (drsp.done)
			div_issue = state_q inside {S_D00, S_D01, S_D11, S_DP};
	end

	assign publish = (state_q == S_FIN) && (!out_valid || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	// Sequencer, state, and registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q <= 24'd65536;
			a_q <= 32'sd3277;
			r_q <= 31'd1678;
			qn_q <= 31'd671089;
			p_q <= '0; v_q <= '0; c00_q <= '0; c01_q <= '0; c11_q <= '0;
			z_q <= '0; at_q <= '0; s_q <= '0;
			tc01_q <= '0; tc11_q <= '0; u00_q <= '0; u01_q <= '0; u11_q <= '0;
			out_valid <= 1'b0;
			position_estimate <= '0;
			velocity_estimate <= '0;
			position_variance <= '0;
			div_start_q <= 1'b0;
			div_num_q <= '0;
		end else begin
			div_start_q <= div_issue;
			if (div_issue) div_num_q <= prod;
			if (publish) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_PERIOD: t_q <= cfg_data[23:0];
					REG_ACCEL:  a_q <= $signed(cfg_data);
					REG_RNOISE: r_q <= cfg_data[30:0];
					REG_QNOISE: qn_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					z_q <= AW'(measured_position);
					state_q <= S_AT;
				end
				S_AT: begin
					at_q <= clampv(rsh(prod, 16), -BIG, BIG);
					state_q <= S_VT;
				end
				S_VT: begin
					tc01_q <= rsh(prod, 16);
					state_q <= S_PRED;
				end
				S_PRED: begin
					p_q <= clampv(p_q + tc01_q + rsh(prod, 17), SMIN, SMAX);
					v_q <= clampv(v_q + at_q, SMIN, SMAX);
					state_q <= S_COV0;
				end
				S_COV0: begin
					tc01_q <= rsh(prod, 16);
					state_q <= S_COV1;
				end
				S_COV1: begin
					tc11_q <= rsh(prod, 16);
					state_q <= S_COV2;
				end
				S_COV2: begin
					c00_q <= clampv(c00_q + (tc01_q <<< 1) + rsh(prod, 16) + AW'(r_q),
						'0, SMAX);
					c01_q <= clampv(c01_q + tc11_q, SMIN, SMAX);
					c11_q <= clampv(c11_q + AW'(r_q), '0, SMAX);
					state_q <= S_DEN;
				end
				S_DEN: begin
					s_q <= s_n;
					if (s_n > 0) state_q <= S_D00;
					else state_q <= S_FIN;
				end
				default: begin
					if (drsp.done) begin
						case (state_q)
							S_D00: u00_q <= drsp.quo;
							S_D01: u01_q <= drsp.quo;
							S_D11: u11_q <= c11_q - drsp.quo;
							S_DP:  p_q <= clampv(p_q + drsp.quo, SMIN, SMAX);
							S_DV:  v_q <= clampv(v_q + drsp.quo, SMIN, SMAX);
							default: ;
						endcase
						if (state_q == S_DV) begin
							c00_q <= clampv(u00_q, '0, SMAX);
							c01_q <= clampv(u01_q, SMIN, SMAX);
							c11_q <= clampv(u11_q, '0, SMAX);
						end
						state_q <= state_t'(state_q + 4'd1);
					end else if (publish) begin
						state_q <= S_IDLE;
						position_estimate <= p_q[31:0];
						velocity_estimate <= v_q[31:0];
						position_variance <= c00_q[30:0];
					end
				end
			endcase
		end
	end
endmodule

@@ rtl/core/kfpv_check.sv @@
// Port checker for the position and velocity tracking filter, with its bind.
`include "kalman_filter_position_velocity_assert.svh"
module kfpv_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [31:0] position_estimate
);
	// A beat accepted at the input is followed by busy.
	`KF_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)
	// A stalled result keeps its payload.
	`KF_ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid && out_stall, $stable(position_estimate))
	// A stalled result stays valid.
	`KF_ASSERT_NEXT(a_keep_valid, clk, arst_n, out_valid && out_stall, out_valid)
endmodule

bind kalman_filter_position_velocity kfpv_check u_check (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.position_estimate(position_estimate)
);
